@@ rtl/dsbr_pkg.sv @@
// ----------------------------------------------------------------------------
// dsbr_pkg: shared definitions for the disc stamp bitmap renderer
// command codes, default geometry, stream layout and the disc shape tables
// ----------------------------------------------------------------------------
package dsbr_pkg;

    // default geometry
    localparam int DEF_SCREEN_WIDTH  = 1024;
    localparam int DEF_SCREEN_HEIGHT = 736;
    localparam int DEF_SHAPE_COUNT   = 3;

    // entries in the radius table
    localparam int RADIUS_TABLE_LEN = 3;

    // field widths
    localparam int CMD_W    = 2;
    localparam int CX_W     = 10;
    localparam int CY_W     = 10;
    localparam int SEL_W    = 8;
    localparam int WADDR_W  = 15;
    localparam int DATA_W   = 32;
    localparam int RAD_W    = 3;
    localparam int SIDX_W   = 2;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // command codes
    typedef logic [CMD_W-1:0] t_cmd;
    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_DRAW  = 2'd1;
    localparam t_cmd CMD_READ  = 2'd2;
    localparam t_cmd CMD_NONE  = 2'd3;

    // radius for a shape index: 2, 3, 4
    function automatic logic [RAD_W-1:0] disc_radius(input logic [SIDX_W-1:0] idx);
        logic [RAD_W-1:0] r;
        case (idx)
            2'd0:    r = 3'd2;
            2'd1:    r = 3'd3;
            2'd2:    r = 3'd4;
            default: r = 3'd2;
        endcase
        return r;
    endfunction

    // half width of a disc row: largest dx with dx*dx + dy*dy <= r*r + r
    function automatic logic [RAD_W-1:0] disc_half(input logic [SIDX_W-1:0] idx,
                                                  input logic [3:0]        ady);
        logic [RAD_W-1:0] h;
        h = 3'd0;
        case (idx)
            2'd1: begin
                case (ady)
                    4'd0, 4'd1: h = 3'd3;
                    4'd2:       h = 3'd2;
                    4'd3:       h = 3'd1;
                    default:    h = 3'd0;
                endcase
            end
            2'd2: begin
                case (ady)
                    4'd0, 4'd1, 4'd2: h = 3'd4;
                    4'd3:             h = 3'd3;
                    4'd4:             h = 3'd2;
                    default:          h = 3'd0;
                endcase
            end
            default: begin
                case (ady)
                    4'd0, 4'd1: h = 3'd2;
                    4'd2:       h = 3'd1;
                    default:    h = 3'd0;
                endcase
            end
        endcase
        return h;
    endfunction

endpackage

@@ rtl/disc_stamp_bitmap_renderer.sv @@
// ----------------------------------------------------------------------------
// disc_stamp_bitmap_renderer: 1 bpp frame bitmap with filled-disc stamping
// clear, draw-disc and read-word commands over a word-wide bitmap memory
// ----------------------------------------------------------------------------
// sequence: a draw goes through setup, then a read and a write state for each
//   touched word (up to 9 rows x 2 words), then done; a read goes through
//   address check, capture and done; clear writes all STORE_WORDS words, then done
// throughput: one item at a time, bounded by the single memory port pair that
//   does every read-modify-write of a disc row word
// reset: synchronous active low; afterwards a clearing pass writes zero to all
//   STORE_WORDS words (23552 by default) with s_tready held low
// ----------------------------------------------------------------------------
module disc_stamp_bitmap_renderer
    import dsbr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int SHAPE_COUNT   = DEF_SHAPE_COUNT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command[1:0], center_x[11:2], center_y[21:12], radius_sel[29:22],
    // word_address[44:30], zero fill above
    input  logic [S_TDATA_W-1:0] s_tdata,
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_data[31:0], drawn[32], zero fill above
    output logic [M_TDATA_W-1:0] m_tdata
);

    // bitmap geometry
    localparam int ROW_WORDS   = (SCREEN_WIDTH + 31) / 32;
    localparam int STORE_WORDS = SCREEN_HEIGHT * ROW_WORDS;
    localparam int AW          = $clog2(STORE_WORDS);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_RDQ   = 3'd5;
    localparam logic [2:0] S_RDC   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // input field unpacking
    logic [CMD_W-1:0]   w_cmd;
    logic [CX_W-1:0]    w_cx;
    logic [CY_W-1:0]    w_cy;
    logic [SEL_W-1:0]   w_sel;
    logic [WADDR_W-1:0] w_waddr;

    assign w_cmd   = s_tdata[1:0];
    assign w_cx    = s_tdata[11:2];
    assign w_cy    = s_tdata[21:12];
    assign w_sel   = s_tdata[29:22];
    assign w_waddr = s_tdata[44:30];

    // control state
    logic [2:0]        r_state,     n_state;
    logic              r_boot,      n_boot;      // clearing pass after reset
    logic [AW-1:0]     r_clr,       n_clr;
    logic              r_m_valid,   n_m_valid;

    // item working registers
    logic [CMD_W-1:0]  r_cmd,       n_cmd;
    logic [CX_W-1:0]   r_cx,        n_cx;
    logic [CY_W-1:0]   r_cy,        n_cy;
    logic [SIDX_W-1:0] r_sidx,      n_sidx;
    logic [AW-1:0]     r_addr,      n_addr;
    logic              r_addr_ok,   n_addr_ok;
    logic [3:0]        r_dy,        n_dy;        // row step 0 .. 2r
    logic [AW-1:0]     r_row_base,  n_row_base;
    logic              r_word,      n_word;      // second word of a row
    logic              r_drawn,     n_drawn;
    logic [DATA_W-1:0] r_res_data,  n_res_data;
    logic [M_TDATA_W-1:0] r_m_data, n_m_data;

    // memory ports
    logic              w_we;
    logic [AW-1:0]     w_mwaddr;
    logic [DATA_W-1:0] w_mwdata;
    logic              w_re;
    logic [AW-1:0]     w_mraddr;
    logic [DATA_W-1:0] w_rdata;

    // selector fallback: out of range shapes use the first table entry
    logic [SIDX_W-1:0] w_sidx_in;
    always_comb begin
        if (32'(w_sel) >= SHAPE_COUNT || 32'(w_sel) >= RADIUS_TABLE_LEN) begin
            w_sidx_in = '0;
        end else begin
            w_sidx_in = SIDX_W'(w_sel);
        end
    end

    // disc geometry of the current item
    logic [RAD_W-1:0]  w_rad;
    logic [CX_W:0]     w_cx_hi;
    logic [CY_W:0]     w_cy_hi;
    logic              w_on_screen;
    logic [CY_W-1:0]   w_py0;
    logic [3:0]        w_ady;
    logic [3:0]        w_dy_last;
    logic [RAD_W-1:0]  w_half;
    logic [CX_W:0]     w_lo;
    logic [CX_W:0]     w_hi;
    logic [CX_W-5:0]   w_w0;
    logic [CX_W-5:0]   w_w1;
    logic [CX_W-5:0]   w_wc;
    logic [4:0]        w_lo_b;
    logic [4:0]        w_hi_b;
    logic [DATA_W-1:0] w_mask;
    logic [AW-1:0]     w_word_addr;

    assign w_rad   = disc_radius(r_sidx);
    assign w_cx_hi = {1'b0, r_cx} + {{(CX_W-RAD_W+1){1'b0}}, w_rad};
    assign w_cy_hi = {1'b0, r_cy} + {{(CY_W-RAD_W+1){1'b0}}, w_rad};

    // the whole disc has to sit on screen
    assign w_on_screen = ({{(CX_W-RAD_W){1'b0}}, w_rad} <= r_cx) &&
                         (32'(w_cx_hi) < SCREEN_WIDTH) &&
                         ({{(CY_W-RAD_W){1'b0}}, w_rad} <= r_cy) &&
                         (32'(w_cy_hi) < SCREEN_HEIGHT);
    assign w_py0 = r_cy - {{(CY_W-RAD_W){1'b0}}, w_rad};

    // row offset from the center and the span of set pixels in this row
    assign w_ady     = (r_dy >= {1'b0, w_rad}) ? (r_dy - {1'b0, w_rad})
                                               : ({1'b0, w_rad} - r_dy);
    assign w_dy_last = {w_rad, 1'b0};
    assign w_half    = disc_half(r_sidx, w_ady);
    assign w_lo      = {1'b0, r_cx} - {{(CX_W-RAD_W+1){1'b0}}, w_half};
    assign w_hi      = {1'b0, r_cx} + {{(CX_W-RAD_W+1){1'b0}}, w_half};
    assign w_w0      = w_lo[CX_W:5];
    assign w_w1      = w_hi[CX_W:5];
    assign w_wc      = r_word ? w_w1 : w_w0;

    // bit mask of the span inside the current word
    assign w_lo_b = (w_w0 == w_wc) ? w_lo[4:0] : 5'd0;
    assign w_hi_b = (w_w1 == w_wc) ? w_hi[4:0] : 5'd31;
    assign w_mask = ({DATA_W{1'b1}} << w_lo_b) & ({DATA_W{1'b1}} >> (5'd31 - w_hi_b));

    assign w_word_addr = r_row_base + AW'(w_wc);

    // memory access steering
    always_comb begin
        w_we     = 1'b0;
        w_mwaddr = w_word_addr;
        w_mwdata = w_rdata | w_mask;
        w_re     = 1'b0;
        w_mraddr = w_word_addr;
        case (r_state)
            S_CLEAR: begin
                w_we     = 1'b1;
                w_mwaddr = r_clr;
                w_mwdata = '0;
            end
            S_RD: begin
                w_re = 1'b1;
            end
            S_WR: begin
                w_we = 1'b1;
            end
            S_RDQ: begin
                w_re     = 1'b1;
                w_mraddr = r_addr;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign s_tready = (r_state == S_IDLE);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_boot     = r_boot;
        n_clr      = r_clr;
        n_m_valid  = r_m_valid;
        n_m_data   = r_m_data;
        n_cmd      = r_cmd;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_sidx     = r_sidx;
        n_addr     = r_addr;
        n_addr_ok  = r_addr_ok;
        n_dy       = r_dy;
        n_row_base = r_row_base;
        n_word     = r_word;
        n_drawn    = r_drawn;
        n_res_data = r_res_data;

        // result taken downstream
        if (r_m_valid && m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_cmd      = w_cmd;
                    n_cx       = w_cx;
                    n_cy       = w_cy;
                    n_sidx     = w_sidx_in;
                    n_addr     = AW'(w_waddr);
                    n_addr_ok  = (32'(w_waddr) < STORE_WORDS);
                    n_drawn    = 1'b0;
                    n_res_data = '0;
                    n_clr      = '0;
                    case (w_cmd)
                        CMD_CLEAR: n_state = S_CLEAR;
                        CMD_DRAW:  n_state = S_SETUP;
                        CMD_READ:  n_state = S_RDQ;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(STORE_WORDS - 1)) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? S_IDLE : S_DONE;
                end
            end
            S_SETUP: begin
                n_dy       = '0;
                n_word     = 1'b0;
                n_row_base = AW'(int'(w_py0) * ROW_WORDS);
                n_state    = w_on_screen ? S_RD : S_DONE;
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                if (!r_word && (w_w1 != w_w0)) begin
                    n_word  = 1'b1;
                    n_state = S_RD;
                end else if (r_dy == w_dy_last) begin
                    n_drawn = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_word     = 1'b0;
                    n_dy       = r_dy + 4'd1;
                    n_row_base = r_row_base + AW'(ROW_WORDS);
                    n_state    = S_RD;
                end
            end
            S_RDQ: begin
                n_state = r_addr_ok ? S_RDC : S_DONE;
            end
            S_RDC: begin
                n_res_data = w_rdata;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!r_m_valid || m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {{(M_TDATA_W-DATA_W-1){1'b0}}, r_drawn, r_res_data};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_boot    <= 1'b1;
            r_clr     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_boot    <= n_boot;
            r_clr     <= n_clr;
            r_m_valid <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_m_data   <= n_m_data;
        r_cmd      <= n_cmd;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_sidx     <= n_sidx;
        r_addr     <= n_addr;
        r_addr_ok  <= n_addr_ok;
        r_dy       <= n_dy;
        r_row_base <= n_row_base;
        r_word     <= n_word;
        r_drawn    <= n_drawn;
        r_res_data <= n_res_data;
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    // bitmap store
    dsbr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_WORDS),
        .AW    (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_mwaddr),
        .i_wdata (w_mwdata),
        .i_re    (w_re),
        .i_raddr (w_mraddr),
        .o_rdata (w_rdata)
    );

    // no item is taken while the bitmap is being cleared
    a_no_accept_in_clear: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_tready
    ) else $error("item accepted during clearing pass");

    // the row step never runs past the bottom row of the disc
    a_row_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_WR) |-> (r_dy <= w_dy_last)
    ) else $error("disc row step out of range");

    // a finished item waits while the output register is still occupied
    a_done_waits: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_m_valid && !m_tready) |=>
            (r_state == S_DONE && m_tvalid)
    ) else $error("result lost while output stalled");

    // only a draw command reports a stamped disc
    a_drawn_only_draw: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_drawn) |-> (r_cmd == CMD_DRAW)
    ) else $error("drawn flag set for a non-draw command");

endmodule

@@ rtl/dsbr_ram.sv @@
// ----------------------------------------------------------------------------
// dsbr_ram: generic single-write, single-read memory
// one write port, one read port with registered read data held when idle
// ----------------------------------------------------------------------------
module dsbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ test/disc_stamp_bitmap_renderer_tb.sv @@
// ----------------------------------------------------------------------------
// disc_stamp_bitmap_renderer_tb: self-checking bench for the disc renderer
// drives clear, draw, read and unused commands over the input stream, keeps
// its own copy of the frame bitmap, and checks every result item in order
// ----------------------------------------------------------------------------
module disc_stamp_bitmap_renderer_tb;
    import dsbr_pkg::*;

    // geometry of the default build
    localparam int SCREEN_W    = DEF_SCREEN_WIDTH;
    localparam int SCREEN_H    = DEF_SCREEN_HEIGHT;
    localparam int SHAPE_COUNT = DEF_SHAPE_COUNT;
    localparam int ROW_WORDS   = (SCREEN_W + 31) / 32;
    localparam int STORE_WORDS = SCREEN_H * ROW_WORDS;

    // random part of the run, the tail of it without any idling
    localparam int RANDOM_ITEMS = 1600;
    localparam int CALM_TAIL    = 200;
    localparam int CLEAR_BUDGET = 6;

    // reset clearing pass plus every clear, with wide margin for stalls
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 64;

    // radius for each shape index
    localparam int DISC_RADII [RADIUS_TABLE_LEN] = '{2, 3, 4};

    typedef struct packed {
        logic [DATA_W-1:0] word;
        logic              drawn;
    } t_disc_result;

    // ------------------------------------------------------------------------
    // scoreboard: bitmap shadow and the queue of pending result items
    // ------------------------------------------------------------------------
    class disc_frame_board;
        bit [DATA_W-1:0] frame [STORE_WORDS];
        t_disc_result    pending_results [$];
        int              failures;

        function new();
            failures = 0;
            foreach (frame[i]) frame[i] = '0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // only the first ten failures get a line of their own
        function void report(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            if (failures < 10)
                $display("mismatch %0s: expected %h, got %h", what, want, got);
            failures++;
        endfunction

        // work out the result of an accepted item and update the bitmap
        function void note_item(logic [S_TDATA_W-1:0] item);
            t_cmd         cmd;
            int           cx, cy, sel, addr, r, dx, dy, px, py;
            t_disc_result res;
            cmd  = item[1:0];
            cx   = item[11:2];
            cy   = item[21:12];
            sel  = item[29:22];
            addr = item[44:30];
            res  = '0;
            case (cmd)
                CMD_CLEAR: begin
                    foreach (frame[i]) frame[i] = '0;
                end
                CMD_DRAW: begin
                    // selectors past the table fall back to the smallest disc
                    if (sel >= SHAPE_COUNT || sel >= RADIUS_TABLE_LEN)
                        sel = 0;
                    r = DISC_RADII[sel];
                    if (cx >= r && cx + r < SCREEN_W && cy >= r && cy + r < SCREEN_H) begin
                        for (dy = -r; dy <= r; dy++) begin
                            for (dx = -r; dx <= r; dx++) begin
                                if (dx * dx + dy * dy <= r * r + r) begin
                                    px = cx + dx;
                                    py = cy + dy;
                                    frame[py * ROW_WORDS + px / 32][px % 32] = 1'b1;
                                end
                            end
                        end
                        res.drawn = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (addr < STORE_WORDS)
                        res.word = frame[addr];
                end
                default: ;
            endcase
            pending_results.push_back(res);
        endfunction

        // compare a result item with the oldest pending one
        function void check_item(logic [M_TDATA_W-1:0] beat);
            t_disc_result want;
            if (pending_results.size() == 0) begin
                if (failures < 10)
                    $display("unexpected result item %h", beat);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (beat[31:0] !== want.word)
                report("read_data", want.word, beat[31:0]);
            if (beat[32] !== want.drawn)
                report("drawn", DATA_W'(want.drawn), DATA_W'(beat[32]));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // command[1:0], center_x[11:2], center_y[21:12], radius_sel[29:22],
    // word_address[44:30], zero fill above
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // read_data[31:0], drawn[32], zero fill above
    logic [M_TDATA_W-1:0] m_tdata;

    disc_stamp_bitmap_renderer i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    disc_frame_board board = new();

    int cycle_count = 0;
    bit quiet       = 1'b0;   // set for the tail of the run: no idling at all

    // recent disc centers, so reads and new discs land where bits are set
    int cx_hist [$];
    int cy_hist [$];

    // ------------------------------------------------------------------------
    // clock and timeout
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: random stall bursts, checked at the rising edge
    // ------------------------------------------------------------------------
    initial begin
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                m_tready = 1'b0;
                hold--;
            end else begin
                m_tready = 1'b1;
                // no new stall starts while cycle_count / 1024 is a multiple of four
                if (!quiet && (cycle_count / 1024) % 4 != 0 && $urandom_range(0, 4) == 0)
                    hold = $urandom_range(1, 17);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            board.check_item(m_tdata);
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    function automatic logic [S_TDATA_W-1:0] pack_item(t_cmd cmd, int cx, int cy,
                                                      int sel, int addr);
        return {3'b000, WADDR_W'(addr), SEL_W'(sel), CY_W'(cy), CX_W'(cx), cmd};
    endfunction

    // offer one item from a falling edge, hold it until taken, then maybe idle
    task automatic send_item(logic [S_TDATA_W-1:0] item, bit allow_gap);
        s_tdata  = item;
        s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        board.note_item(item);
        if (item[1:0] == CMD_DRAW && cx_hist.size() < 64) begin
            cx_hist.push_back(int'(item[11:2]));
            cy_hist.push_back(int'(item[21:12]));
        end else if (item[1:0] == CMD_DRAW) begin
            void'(cx_hist.pop_front());
            void'(cy_hist.pop_front());
            cx_hist.push_back(int'(item[11:2]));
            cy_hist.push_back(int'(item[21:12]));
        end
        @(negedge i_clk);
        if (allow_gap && !quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
    endtask

    // clamp a coordinate into the field range
    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
    endfunction

    // random item, biased toward discs that overlap and reads that see them
    task automatic send_random_item(bit allow_gap, inout int clears_left);
        int pick, k, cx, cy, sel, row, col;
        pick = $urandom_range(0, 99);
        sel  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 2);
        if (clears_left > 0 && $urandom_range(0, 299) == 0) begin
            clears_left--;
            send_item(pack_item(CMD_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 255), $urandom_range(0, 32767)), allow_gap);
        end else if (pick < 35) begin
            // disc near an earlier one, or anywhere on screen
            if (cx_hist.size() > 0 && $urandom_range(0, 2) != 0) begin
                k  = $urandom_range(0, cx_hist.size() - 1);
                cx = clamp_coord(cx_hist[k] + $urandom_range(0, 12) - 6);
                cy = clamp_coord(cy_hist[k] + $urandom_range(0, 12) - 6);
            end else begin
                cx = $urandom_range(4, SCREEN_W - 5);
                cy = $urandom_range(4, SCREEN_H - 5);
            end
            send_item(pack_item(CMD_DRAW, cx, cy, sel, $urandom_range(0, 32767)), allow_gap);
        end else if (pick < 45) begin
            // disc hugging or crossing a screen edge
            cx = $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(1018, 1023);
            case ($urandom_range(0, 2))
                0:       cy = $urandom_range(0, 5);
                1:       cy = $urandom_range(SCREEN_H - 7, SCREEN_H - 1);
                default: cy = $urandom_range(4, 1023);
            endcase
            if ($urandom_range(0, 1))
                {cx, cy} = {cy > 1023 ? 1023 : cy, cx};
            send_item(pack_item(CMD_DRAW, cx, cy, sel, $urandom_range(0, 32767)), allow_gap);
        end else if (pick < 80 && cx_hist.size() > 0) begin
            // read a word that a recent disc touched or nearly touched
            k   = $urandom_range(0, cx_hist.size() - 1);
            row = clamp_coord(cy_hist[k] + $urandom_range(0, 8) - 4);
            col = clamp_coord(cx_hist[k] + $urandom_range(0, 8) - 4);
            send_item(pack_item(CMD_READ, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 255), row * ROW_WORDS + col / 32), allow_gap);
        end else begin
            // noise over the full field ranges, reads and the unused command
            send_item(pack_item($urandom_range(0, 1) ? CMD_READ : CMD_NONE,
                                $urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 255), $urandom_range(0, 32767)), allow_gap);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int clears_left;
        int n;
        clears_left = CLEAR_BUDGET;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty bitmap, corner discs, word straddle, rejects, reads
        send_item(pack_item(CMD_READ, 0, 0, 0, 0), 1'b0);
        send_item(pack_item(CMD_DRAW, 2, 2, 0, 0), 1'b0);                // smallest legal corner
        send_item(pack_item(CMD_READ, 0, 0, 0, 2 * ROW_WORDS), 1'b0);
        send_item(pack_item(CMD_DRAW, 1020, 732, 1, 0), 1'b0);           // radius 3 at far corner
        send_item(pack_item(CMD_DRAW, 1019, 731, 2, 0), 1'b0);           // radius 4 at far corner
        send_item(pack_item(CMD_READ, 0, 0, 0, 731 * ROW_WORDS + 31), 1'b0);
        send_item(pack_item(CMD_DRAW, 1021, 733, 3, 0), 1'b1);           // selector past table
        send_item(pack_item(CMD_READ, 0, 0, 0, STORE_WORDS - 1), 1'b1);  // last word
        send_item(pack_item(CMD_DRAW, 1, 100, 255, 0), 1'b1);            // off left edge
        send_item(pack_item(CMD_DRAW, 3, 100, 2, 0), 1'b1);              // radius 4 off left
        send_item(pack_item(CMD_DRAW, 1020, 100, 2, 0), 1'b1);           // off right edge
        send_item(pack_item(CMD_DRAW, 500, 1, 0, 0), 1'b1);              // off top
        send_item(pack_item(CMD_DRAW, 500, 732, 2, 0), 1'b1);            // off bottom
        send_item(pack_item(CMD_DRAW, 1023, 1023, 255, 32767), 1'b1);    // all fields high
        send_item(pack_item(CMD_DRAW, 32, 50, 2, 0), 1'b0);              // straddles two words
        send_item(pack_item(CMD_READ, 0, 0, 0, 50 * ROW_WORDS), 1'b0);
        send_item(pack_item(CMD_READ, 1023, 1023, 255, 50 * ROW_WORDS + 1), 1'b0);
        send_item(pack_item(CMD_READ, 0, 0, 0, STORE_WORDS), 1'b1);      // just past the store
        send_item(pack_item(CMD_READ, 0, 0, 0, 32767), 1'b1);            // top of address range
        send_item(pack_item(CMD_NONE, 1023, 1023, 255, 32767), 1'b1);    // unused command
        send_item(pack_item(CMD_NONE, 0, 0, 0, 0), 1'b1);
        send_item(pack_item(CMD_CLEAR, 0, 0, 0, 0), 1'b1);
        send_item(pack_item(CMD_READ, 0, 0, 0, 50 * ROW_WORDS), 1'b1);   // gone after clear
        send_item(pack_item(CMD_READ, 0, 0, 0, STORE_WORDS - 1), 1'b1);

        // random part; sender calm for the first fifth of every 200 items
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= RANDOM_ITEMS - CALM_TAIL)
                quiet = 1'b1;
            send_random_item(n % 200 >= 40, clears_left);
        end
        s_tvalid = 1'b0;

        // drain, then give the block a few more cycles to show strays
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.failures == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/dsbr_pkg.sv
rtl/dsbr_ram.sv
rtl/disc_stamp_bitmap_renderer.sv
test/disc_stamp_bitmap_renderer_tb.sv
